// File: src/wbtd_pkg.sv
// Package for the wavelet band threshold despeckle block.
// Holds register widths, reset values, register indexes and the flag struct.
// No dependencies.
package wbtd_pkg;

	// Defaults of the top level parameters.
	localparam int DATA_WIDTH_DEF = 24;
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 4096;

	// Configuration port.
	localparam int CFG_DATA_W = 23;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_HARD_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LEVEL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_N_SIGMA = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_ROWS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_COLS = 3'd4;

	// Register widths.
	localparam int NOISE_W = 23;
	localparam int NSIG_W = 12;
	localparam int NROWS_W = 13;
	localparam int NCOLS_W = 11;

	// Register reset values.
	localparam logic HARD_MODE_RST = 1'b1;
	localparam logic [NOISE_W-1:0] NOISE_LEVEL_RST = 23'd256;
	localparam logic [NSIG_W-1:0] N_SIGMA_RST = 12'd768;
	localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 13'd512;
	localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 11'd512;

	// Fraction bits of n_sigma; the product is scaled down by this much.
	localparam int LEVEL_FRAC = 8;

	// Entries of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Classification of one pixel, made by the front and used by the back.
	typedef struct packed {
		logic has_prev;  // a pixel of the previous row is released
		logic interior;  // the released pixel may be despeckled
		logic last_row;  // the pixel itself is released too
		logic row_end;   // last column of its row
	} wbtd_flags_t;

endpackage

// File: src/wavelet_band_threshold_despeckle.sv
// Top level of the wavelet band threshold despeckle block.
// Holds the configuration registers and joins front, queue and back.
// Depends on wbtd_pkg, wbtd_front, wbtd_fifo and wbtd_back.
//
// Usage: coefficients of one wavelet band enter in raster order on the input
// channel (in_valid, in_stall, coefficient); one transfer per cycle is taken while in_stall is low.
// Each coefficient is thresholded (hard, or soft with a halved level), and
// the pixel one row above is released when it arrives, after isolated
// nonzero interior pixels have been zeroed. The first row releases nothing;
// on the last row each pixel is released a second time as itself, and the
// final pixel of the band carries last.
// After pixel (r,c) is taken, its result for row r-1 passes the front register,
// queue, back stage and output register; a last-row pixel itself follows.
// Before the last row one coefficient is taken per cycle while out_stall is low;
// on the last row each pixel gives two results and the output port sets the pace.
// When the receiver holds out_stall the output register, the back stage, the
// four-entry queue and the front register fill in turn, and only then is
// in_stall raised. Reset clears the registers to their defaults and the
// raster position to the first pixel; the line buffers need no clearing.
// The user writes registers through cfg_write_en, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce it.
module wavelet_band_threshold_despeckle
	import wbtd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  coefficient,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  value,
	output logic [$clog2(MAX_ROWS)-1:0]   row,
	output logic [$clog2(MAX_COLS)-1:0]   col,
	output logic                          last
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int FLAG_W = $bits(wbtd_flags_t);
	localparam int QW = DATA_WIDTH + RW + CW + FLAG_W;

	// Configuration registers; bits above a register's width are dropped.
	logic               hard_mode_q;
	logic [NOISE_W-1:0] noise_level_q;
	logic [NSIG_W-1:0]  n_sigma_q;
	logic [NROWS_W-1:0] num_rows_q;
	logic [NCOLS_W-1:0] num_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_mode_q <= HARD_MODE_RST;
			noise_level_q <= NOISE_LEVEL_RST;
			n_sigma_q <= N_SIGMA_RST;
			num_rows_q <= NUM_ROWS_RST;
			num_cols_q <= NUM_COLS_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_HARD_MODE: begin
					hard_mode_q <= cfg_data[0];
				end
				REG_NOISE_LEVEL: begin
					noise_level_q <= cfg_data[NOISE_W-1:0];
				end
				REG_N_SIGMA: begin
					n_sigma_q <= cfg_data[NSIG_W-1:0];
				end
				REG_NUM_ROWS: begin
					num_rows_q <= cfg_data[NROWS_W-1:0];
				end
				REG_NUM_COLS: begin
					num_cols_q <= cfg_data[NCOLS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front: classification and thresholding.
	logic                         q_push;
	logic                         q_full;
	logic                         q_valid;
	logic                         q_pop;
	logic signed [DATA_WIDTH-1:0] f_t;
	logic [RW-1:0]                f_r;
	logic [CW-1:0]                f_c;
	wbtd_flags_t                  f_flags;
	logic [QW-1:0]                q_wdata;
	logic [QW-1:0]                q_rdata;
	logic signed [DATA_WIDTH-1:0] b_t;
	logic [RW-1:0]                b_r;
	logic [CW-1:0]                b_c;
	wbtd_flags_t                  b_flags;

	wbtd_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hard_mode(hard_mode_q),
		.noise_level(noise_level_q),
		.n_sigma(n_sigma_q),
		.num_rows(num_rows_q),
		.num_cols(num_cols_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coefficient(coefficient),
		.q_push(q_push),
		.q_full(q_full),
		.t_out(f_t),
		.r_out(f_r),
		.c_out(f_c),
		.flags_out(f_flags)
	);

	assign q_wdata = {f_t, f_r, f_c, f_flags};

	// Queue that lets the front keep taking transfers while the back waits.
	wbtd_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_wdata),
		.full(q_full),
		.valid(q_valid),
		.pop(q_pop),
		.pop_data(q_rdata)
	);

	assign {b_t, b_r, b_c, b_flags} = q_rdata;

	// Back: line buffers, despeckle and output register.
	wbtd_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.t_in(b_t),
		.r_in(b_r),
		.c_in(b_c),
		.flags_in(b_flags),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.row(row),
		.col(col),
		.last(last)
	);

	// A full queue always has an entry to offer.
	a_full_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> q_valid)
		else $error("queue reports full with no entry");

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");

	// The back pops only an entry that is there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	// The input is held off only because the queue is full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled with room in the queue");

endmodule

// File: src/wbtd_front.sv
// Front part: accepts coefficients, tracks the raster position, classifies
// each pixel and applies the threshold. Depends on wbtd_pkg.
module wbtd_front
	import wbtd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hard_mode,
	input  logic [NOISE_W-1:0]            noise_level,
	input  logic [NSIG_W-1:0]             n_sigma,
	input  logic [NROWS_W-1:0]            num_rows,
	input  logic [NCOLS_W-1:0]            num_cols,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [DATA_WIDTH-1:0]  coefficient,
	output logic                          q_push,
	input  logic                          q_full,
	output logic signed [DATA_WIDTH-1:0]  t_out,
	output logic [$clog2(MAX_ROWS)-1:0]   r_out,
	output logic [$clog2(MAX_COLS)-1:0]   c_out,
	output wbtd_flags_t                   flags_out
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CMPW = (CW + 1 > NCOLS_W) ? CW + 1 : NCOLS_W;
	localparam int RMPW = (RW + 1 > NROWS_W) ? RW + 1 : NROWS_W;
	localparam int PROD_W = NSIG_W + NOISE_W;
	localparam int SCL_W = PROD_W - LEVEL_FRAC;
	localparam int LVL_W = DATA_WIDTH - 1;
	localparam int SATW = (SCL_W > LVL_W) ? SCL_W : LVL_W;

	// Threshold level, refreshed every cycle from the registers.
	logic [PROD_W-1:0] prod;
	logic [SCL_W-1:0]  scaled;
	logic [LVL_W-1:0]  lvl_sat;
	logic [LVL_W-1:0]  level_q;

	assign prod = PROD_W'(n_sigma) * PROD_W'(noise_level);
	assign scaled = prod[PROD_W-1:LEVEL_FRAC];

	always_comb begin
		if (SATW'(scaled) > SATW'({LVL_W{1'b1}})) begin
			lvl_sat = {LVL_W{1'b1}};
		end else begin
			lvl_sat = LVL_W'(scaled);
		end
	end

	always_ff @(posedge clk) begin
		level_q <= hard_mode ? lvl_sat : (lvl_sat >> 1);
	end

	// Band size, clamped to at least one column and two rows and at most MAX_COLS and MAX_ROWS.
	logic [CMPW-1:0] ncols_x;
	logic [CMPW-1:0] cols_c;
	logic [RMPW-1:0] nrows_x;
	logic [RMPW-1:0] rows_c;

	assign ncols_x = CMPW'(num_cols);
	assign nrows_x = RMPW'(num_rows);

	always_comb begin
		if (ncols_x == '0) begin
			cols_c = CMPW'(1);
		end else if (ncols_x > CMPW'(MAX_COLS)) begin
			cols_c = CMPW'(MAX_COLS);
		end else begin
			cols_c = ncols_x;
		end
		if (nrows_x < RMPW'(2)) begin
			rows_c = RMPW'(2);
		end else if (nrows_x > RMPW'(MAX_ROWS)) begin
			rows_c = RMPW'(MAX_ROWS);
		end else begin
			rows_c = nrows_x;
		end
	end

	// Raster position of the next coefficient.
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	wbtd_flags_t   flags_now;
	logic          accept;

	assign flags_now.row_end = CMPW'(col_q) >= cols_c - CMPW'(1);
	assign flags_now.last_row = RMPW'(row_q) >= rows_c - RMPW'(1);
	assign flags_now.has_prev = row_q != '0;
	assign flags_now.interior = (RMPW'(row_q) >= RMPW'(2)) && (col_q != '0) &&
		(CMPW'(col_q) + CMPW'(1) < cols_c);

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (flags_now.row_end) begin
				col_q <= '0;
				row_q <= flags_now.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage 1: the accepted coefficient with its position and class.
	logic                         valid_s1;
	logic signed [DATA_WIDTH-1:0] x_s1;
	logic [RW-1:0]                r_s1;
	logic [CW-1:0]                c_s1;
	wbtd_flags_t                  flags_s1;

	assign q_push = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= coefficient;
			r_s1 <= row_q;
			c_s1 <= col_q;
			flags_s1 <= flags_now;
		end
	end

	// Threshold: zero below the level, else keep or shrink toward zero.
	logic [DATA_WIDTH-1:0]        mag;
	logic [DATA_WIDTH-1:0]        lvl_ext;
	logic signed [DATA_WIDTH-1:0] lvl_s;

	assign mag = x_s1[DATA_WIDTH-1] ? (~x_s1 + 1'b1) : x_s1;
	assign lvl_ext = {1'b0, level_q};
	assign lvl_s = lvl_ext;

	always_comb begin
		if (mag < lvl_ext) begin
			t_out = '0;
		end else if (hard_mode) begin
			t_out = x_s1;
		end else if (!x_s1[DATA_WIDTH-1] && (x_s1 != '0)) begin
			t_out = x_s1 - lvl_s;
		end else begin
			t_out = x_s1 + lvl_s;
		end
	end

	assign r_out = r_s1;
	assign c_out = c_s1;
	assign flags_out = flags_s1;

endmodule

// File: src/wbtd_fifo.sv
// Short queue between the front and back parts of the despeckle block.
// Depends on wbtd_pkg for the default depth.
module wbtd_fifo
	import wbtd_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full = count_q == NW'(DEPTH);
	assign valid = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/wbtd_back.sv
// Back part: line buffers, despeckle decision and output register.
// Depends on wbtd_pkg for the flag struct.
module wbtd_back
	import wbtd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic signed [DATA_WIDTH-1:0]  t_in,
	input  logic [$clog2(MAX_ROWS)-1:0]   r_in,
	input  logic [$clog2(MAX_COLS)-1:0]   c_in,
	input  wbtd_flags_t                   flags_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [DATA_WIDTH-1:0]  value,
	output logic [$clog2(MAX_ROWS)-1:0]   row,
	output logic [$clog2(MAX_COLS)-1:0]   col,
	output logic                          last
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	// Thresholded values of the previous row and final nonzero flags of the
	// row before it.
	logic signed [DATA_WIDTH-1:0] pend_mem [MAX_COLS];
	logic                         flag_mem [MAX_COLS];

	logic [CW-1:0] c_next;
	assign c_next = (c_in == CW'(MAX_COLS - 1)) ? '0 : c_in + 1'b1;

	// Stage 2: one item with its line buffer reads.
	logic                         valid_s2;
	logic signed [DATA_WIDTH-1:0] t_s2;
	logic [RW-1:0]                r_s2;
	logic [CW-1:0]                c_s2;
	wbtd_flags_t                  flags_s2;
	logic signed [DATA_WIDTH-1:0] v_s2;
	logic signed [DATA_WIDTH-1:0] right_s2;
	logic                         up_nz_s2;
	logic                         second_q;
	logic                         left_nz_q;

	// Output register.
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic [RW-1:0]                row_q;
	logic [CW-1:0]                col_q;
	logic                         last_q;

	logic                         sel_prev;
	logic                         has_any;
	logic                         load;
	logic                         done_s2;
	logic                         emit_prev;
	logic                         kill;
	logic signed [DATA_WIDTH-1:0] v_final;

	// The released pixel of the previous row goes first, the pixel itself
	// (last row only) second.
	assign sel_prev = flags_s2.has_prev && !second_q;
	assign has_any = sel_prev || flags_s2.last_row;
	assign load = valid_s2 && has_any && (!out_valid_q || !out_stall);
	assign emit_prev = load && sel_prev;
	assign done_s2 = valid_s2 && (!has_any || (load && (!sel_prev || !flags_s2.last_row)));
	assign q_pop = q_valid && (!valid_s2 || done_s2);

	// An isolated nonzero interior pixel is removed.
	assign kill = flags_s2.interior && (v_s2 != '0) && !up_nz_s2 && !left_nz_q &&
		(t_s2 == '0) && (right_s2 == '0);
	assign v_final = kill ? '0 : v_s2;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pend_mem[c_in] <= t_in;
			v_s2 <= pend_mem[c_in];
			right_s2 <= pend_mem[c_next];
			up_nz_s2 <= flag_mem[c_in];
			t_s2 <= t_in;
			r_s2 <= r_in;
			c_s2 <= c_in;
			flags_s2 <= flags_in;
		end
		if (emit_prev) begin
			flag_mem[c_s2] <= v_final != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			second_q <= 1'b0;
			left_nz_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (done_s2) begin
				valid_s2 <= 1'b0;
			end
			if (q_pop || done_s2) begin
				second_q <= 1'b0;
			end else if (emit_prev) begin
				second_q <= 1'b1;
			end
			if (emit_prev) begin
				left_nz_q <= v_final != '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sel_prev) begin
				value_q <= v_final;
				row_q <= r_s2 - 1'b1;
				last_q <= 1'b0;
			end else begin
				value_q <= t_s2;
				row_q <= r_s2;
				last_q <= flags_s2.row_end;
			end
			col_q <= c_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign row = row_q;
	assign col = col_q;
	assign last = last_q;

endmodule
